// ===== design/ibhq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibhq_pkg
// shared types, codes and sizes of the indexed binary heap queue
// ----------------------------------------------------------------------------
package ibhq_pkg;

    localparam int ID_COUNT      = 64;
    localparam int ID_W          = 6;
    localparam int PRI_W         = 32;
    localparam int KIND_W        = 3;
    localparam int STATUS_W      = 3;
    localparam int QS_W          = 7;
    localparam int CAPACITY_DEF  = 64;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXTRACT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHANGE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   element_id;
        logic [PRI_W-1:0]  priority_req;
    } ibhq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     out_element;
        logic [PRI_W-1:0]    out_priority;
        logic [QS_W-1:0]     queue_size;
    } ibhq_rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } ibhq_entry_t;

endpackage
`default_nettype wire

// ===== design/ibhq_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibhq_cmp
// shared priority comparator: high when b must be served strictly before a
// ----------------------------------------------------------------------------
module ibhq_cmp (
    input  wire logic                      min_first,
    input  wire logic [ibhq_pkg::PRI_W-1:0] a,
    input  wire logic [ibhq_pkg::PRI_W-1:0] b,
    output logic                           after
);
    import ibhq_pkg::*;

    assign after = min_first ? (a > b) : (a < b);

endmodule
`default_nettype wire

// ===== design/ibhq_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibhq_core
// heap store, position store and the sift sequencer around one comparator
// ----------------------------------------------------------------------------
module ibhq_core #(
    parameter int CAPACITY = ibhq_pkg::CAPACITY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire ibhq_pkg::ibhq_req_t req,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_data,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output ibhq_pkg::ibhq_rsp_t     res
);
    import ibhq_pkg::*;

    localparam int POS_W = $clog2(CAPACITY + 1);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_OP     = 14'b00000000000010,
        S_TOP    = 14'b00000000000100,
        S_RM1    = 14'b00000000001000,
        S_RM2    = 14'b00000000010000,
        S_CH1    = 14'b00000000100000,
        S_CH2    = 14'b00000001000000,
        S_UP_RD  = 14'b00000010000000,
        S_UP_CMP = 14'b00000100000000,
        S_DN_RD  = 14'b00001000000000,
        S_DN_SEL = 14'b00010000000000,
        S_DN_CMP = 14'b00100000000000,
        S_PLACE  = 14'b01000000000000,
        S_RES    = 14'b10000000000000
    } state_t;

    ibhq_entry_t heap_mem [2**POS_W];
    logic [POS_W-1:0] pos_mem [ID_COUNT];

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [PRI_W-1:0]    pri_reg, pri_next;
    logic [POS_W-1:0]    p_reg, p_next;
    logic [POS_W-1:0]    count_reg, count_next;
    ibhq_entry_t         mov_reg, mov_next;
    logic                sel_right_reg, sel_right_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     oel_reg, oel_next;
    logic [PRI_W-1:0]    opri_reg, opri_next;
    logic [ID_COUNT-1:0] present_reg, present_next;
    logic                min_first_reg;

    ibhq_entry_t      ha_q_reg, hb_q_reg;
    logic [POS_W-1:0] pr_q_reg;

    logic             heap_we, pos_we;
    logic [POS_W-1:0] heap_wa, ha_addr, hb_addr, pos_wd;
    ibhq_entry_t      heap_wd, c_entry;
    logic [ID_W-1:0]  pos_wa, pr_addr;
    logic [PRI_W-1:0] cmp_a, cmp_b;
    logic             cmp_after;
    logic [POS_W:0]   child, child1, count_x;

    ibhq_cmp u_cmp (
        .min_first (min_first_reg),
        .a         (cmp_a),
        .b         (cmp_b),
        .after     (cmp_after)
    );

    assign child   = {p_reg, 1'b0};
    assign child1  = {p_reg, 1'b1};
    assign count_x = {1'b0, count_reg};
    assign c_entry = sel_right_reg ? hb_q_reg : ha_q_reg;

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        ha_q_reg <= heap_mem[ha_addr];
        hb_q_reg <= heap_mem[hb_addr];
        if (pos_we)
        begin
            pos_mem[pos_wa] <= pos_wd;
        end
        pr_q_reg <= pos_mem[pr_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        pri_next       = pri_reg;
        p_next         = p_reg;
        count_next     = count_reg;
        mov_next       = mov_reg;
        sel_right_next = sel_right_reg;
        status_next    = status_reg;
        oel_next       = oel_reg;
        opri_next      = opri_reg;
        present_next   = present_reg;
        heap_we        = 1'b0;
        heap_wa        = p_reg;
        heap_wd        = mov_reg;
        pos_we         = 1'b0;
        pos_wa         = mov_reg.id;
        pos_wd         = p_reg;
        ha_addr        = child[POS_W-1:0];
        hb_addr        = child1[POS_W-1:0];
        pr_addr        = id_reg;
        cmp_a          = ha_q_reg.pri;
        cmp_b          = hb_q_reg.pri;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next   = req.kind;
                    id_next     = req.element_id;
                    pri_next    = req.priority_req;
                    status_next = ST_OK;
                    oel_next    = '0;
                    opri_next   = '0;
                    state_next  = S_OP;
                end
            end
            S_OP:
            begin
                ha_addr = POS_W'(1);
                hb_addr = count_reg;
                state_next = S_RES;
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (present_reg[id_reg])
                        begin
                            status_next = ST_DUP;
                        end
                        else if (count_reg == POS_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            count_next           = count_reg + POS_W'(1);
                            present_next[id_reg] = 1'b1;
                            mov_next             = '{id: id_reg, pri: pri_reg};
                            p_next               = count_reg + POS_W'(1);
                            state_next           = S_UP_RD;
                        end
                    end
                    KIND_EXTRACT, KIND_PEEK:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_TOP;
                        end
                    end
                    KIND_REMOVE, KIND_CHANGE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (!present_reg[id_reg])
                        begin
                            status_next = ST_ABSENT;
                        end
                        else
                        begin
                            state_next = (kind_reg == KIND_REMOVE) ? S_RM1 : S_CH1;
                        end
                    end
                    default:
                    begin
                        state_next = S_RES;
                    end
                endcase
            end
            S_TOP:
            begin
                oel_next  = ha_q_reg.id;
                opri_next = ha_q_reg.pri;
                if (kind_reg == KIND_PEEK)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    present_next[ha_q_reg.id] = 1'b0;
                    count_next = count_reg - POS_W'(1);
                    mov_next   = hb_q_reg;
                    p_next     = POS_W'(1);
                    state_next = (count_reg == POS_W'(1)) ? S_RES : S_DN_RD;
                end
            end
            S_RM1:
            begin
                ha_addr    = pr_q_reg;
                hb_addr    = count_reg;
                p_next     = pr_q_reg;
                state_next = S_RM2;
            end
            S_RM2:
            begin
                present_next[id_reg] = 1'b0;
                count_next = count_reg - POS_W'(1);
                mov_next   = hb_q_reg;
                cmp_a      = ha_q_reg.pri;
                cmp_b      = hb_q_reg.pri;
                if (p_reg == count_reg)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    state_next = cmp_after ? S_UP_RD : S_DN_RD;
                end
            end
            S_CH1:
            begin
                ha_addr    = pr_q_reg;
                p_next     = pr_q_reg;
                state_next = S_CH2;
            end
            S_CH2:
            begin
                mov_next   = '{id: id_reg, pri: pri_reg};
                cmp_a      = ha_q_reg.pri;
                cmp_b      = pri_reg;
                state_next = cmp_after ? S_UP_RD : S_DN_RD;
            end
            S_UP_RD:
            begin
                ha_addr    = p_reg >> 1;
                state_next = (p_reg == POS_W'(1)) ? S_PLACE : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                cmp_a = ha_q_reg.pri;
                cmp_b = mov_reg.pri;
                if (cmp_after)
                begin
                    heap_we    = 1'b1;
                    heap_wd    = ha_q_reg;
                    pos_we     = 1'b1;
                    pos_wa     = ha_q_reg.id;
                    p_next     = p_reg >> 1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_DN_RD:
            begin
                state_next = (child > count_x) ? S_PLACE : S_DN_SEL;
            end
            S_DN_SEL:
            begin
                sel_right_next = (child1 <= count_x) && cmp_after;
                state_next     = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmp_a = mov_reg.pri;
                cmp_b = c_entry.pri;
                if (cmp_after)
                begin
                    heap_we    = 1'b1;
                    heap_wd    = c_entry;
                    pos_we     = 1'b1;
                    pos_wa     = c_entry.id;
                    p_next     = sel_right_reg ? child1[POS_W-1:0] : child[POS_W-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                heap_we    = 1'b1;
                pos_we     = 1'b1;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            present_reg   <= '0;
            min_first_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            present_reg <= present_next;
            if (cfg_valid)
            begin
                min_first_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        id_reg        <= id_next;
        pri_reg       <= pri_next;
        p_reg         <= p_next;
        mov_reg       <= mov_next;
        sel_right_reg <= sel_right_next;
        status_reg    <= status_next;
        oel_reg       <= oel_next;
        opri_reg      <= opri_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RES);

    always_comb
    begin
        res.status       = status_reg;
        res.out_element  = oel_reg;
        res.out_priority = opri_reg;
        res.queue_size   = QS_W'(count_reg);
    end

endmodule
`default_nettype wire

// ===== design/indexed_binary_heap_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue
// priority queue of element ids kept as a binary heap, max- or min-first
// ----------------------------------------------------------------------------
// req channel (req_valid/req_ready/req): one operation word per handshake,
// insert, extract, peek, remove or change priority. rsp channel: one result
// word per request with status, returned element and priority, and size.
// cfg channel: cfg_data sets min-first order; always ready, write only while
// no request is in flight.
// Work per request: a check, a root read for a peek or extract, a read and
// compare for each level a sift-up climbs or a sift-down descends, and a
// position lookup first for remove/change. The single comparator and the
// one-word-per-cycle heap store set this pace. One request at a time:
// req_ready drops after accept.
// The result sits in an output register; the next request is taken while it
// waits for rsp_ready, but the following result holds inside the core.
// Reset empties the queue and selects max-first order; no clearing pass.
// ----------------------------------------------------------------------------
module indexed_binary_heap_queue #(
    parameter int CAPACITY = ibhq_pkg::CAPACITY_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire ibhq_pkg::ibhq_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output ibhq_pkg::ibhq_rsp_t      rsp,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);
    import ibhq_pkg::*;

    logic      res_valid, res_ready;
    ibhq_rsp_t res;
    logic      rsp_valid_reg, rsp_valid_next;
    ibhq_rsp_t rsp_reg;

    ibhq_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid_next = res_ready ? res_valid : rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ===== design/ibhq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibhq_checker
// port-level checks of the heap queue, bound to the top level
// ----------------------------------------------------------------------------
module ibhq_checker #(
    parameter int CAPACITY = ibhq_pkg::CAPACITY_DEF
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire ibhq_pkg::ibhq_rsp_t rsp
);
    import ibhq_pkg::*;

    // a result word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result word dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.queue_size) <= 32'(CAPACITY)))
        else $error("size beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.queue_size == '0)
        else $error("empty status with non-zero size");

endmodule

bind indexed_binary_heap_queue ibhq_checker #(
    .CAPACITY (CAPACITY)
) u_ibhq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire
